FILE: sv/dm3_pkg.sv
package dm3_pkg;

  // Default store geometry
  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;

  localparam int DEPTH_W  = 16;
  localparam int COUNT_W  = 4;
  localparam int SIZE_W   = 9;
  localparam int COORD_W  = 8;
  localparam int WIN_TAPS = 9;

  // Config register file
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_LIMIT  = 2'd2;

  localparam logic [SIZE_W-1:0]  FRAME_WIDTH_RST  = 9'd256;
  localparam logic [SIZE_W-1:0]  FRAME_HEIGHT_RST = 9'd256;
  localparam logic [DEPTH_W-1:0] DEPTH_LIMIT_RST  = 16'd15000;

  // Operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic                 op;
    logic [COORD_W-1:0]   col;
    logic [COORD_W-1:0]   row;
    logic [DEPTH_W-1:0]   depth_mm;
    logic                 sample_ok;
  } in_beat_t;

  typedef struct packed {
    logic [DEPTH_W-1:0] median_mm;
    logic [COUNT_W-1:0] valid_count;
    logic               usable;
  } out_beat_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SETTLE,
    ST_EMIT
  } seq_state_t;

  // Sequencer -> sorter control
  typedef struct packed {
    logic clr;   // start of a query, empty the sorted list
    logic ins;   // read data valid this cycle
    logic emit;  // list final, capture result
  } sort_ctrl_t;

endpackage

FILE: sv/depth_median_3x3_query.sv
// Depth frame store with a masked 3x3 median query. After reset the block
// holds busy high while it zeroes the pixel store, one word per cycle, for
// MAX_HEIGHT * 2**clog2(MAX_WIDTH) words (65536 at the default 256 x 256);
// config writes are taken during that sweep. A beat is taken when start is
// high and busy is low. A write beat returns nothing and leaves busy low.
// A query beat holds busy high after its accept through the states READ,
// with the nine reads of the 3x3 window through the single-port pixel
// memory, SETTLE, in which the last sample enters the sorted list, and
// EMIT, in which the result register captures the result. The result shows
// on out_beat for exactly one cycle with out_valid high; there is no
// backpressure, so the receiver must take it in that cycle. Edge pixels are
// repeated, zero samples are masked, and the median is the element at
// count/2 of the sorted valid samples (upper middle on even counts).
module depth_median_3x3_query
  import dm3_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // command side
  input  logic                  start,
  output logic                  busy,
  input  in_beat_t              in_beat,
  // result side, strobed
  output logic                  out_valid,
  output out_beat_t             out_beat,
  // config write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // store geometry: row-major, column field padded to a power of two
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int AW    = CW + RW;
  localparam int DEPTH = MAX_HEIGHT << CW;

  logic [SIZE_W-1:0]  frame_width_r, frame_height_r;
  logic [DEPTH_W-1:0] depth_limit_r;

  logic               ram_en, ram_we;
  logic [AW-1:0]      ram_addr;
  logic [DEPTH_W-1:0] ram_wdata, ram_rdata;
  sort_ctrl_t         sort_ctrl;
  logic [DEPTH_W-1:0] median;
  logic [COUNT_W-1:0] count;

  logic      out_valid_r, out_valid_nxt;
  out_beat_t out_beat_r, out_beat_nxt;

  // config registers; unknown index is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
      depth_limit_r  <= DEPTH_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata[SIZE_W-1:0];
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_wdata[SIZE_W-1:0];
        CFG_DEPTH_LIMIT:  depth_limit_r  <= cfg_wdata[DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer: clear sweep, writes, window read walk
  dm3_seq #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_beat      (in_beat),
    .frame_width  (frame_width_r),
    .frame_height (frame_height_r),
    .busy         (busy),
    .ram_en       (ram_en),
    .ram_we       (ram_we),
    .ram_addr     (ram_addr),
    .ram_wdata    (ram_wdata),
    .sort_ctrl    (sort_ctrl)
  );

  // pixel store, single port, registered read
  dm3_ram #(
    .WIDTH (DEPTH_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // sorted insertion of nonzero window samples
  dm3_sorter u_sorter (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (sort_ctrl),
    .rd_val (ram_rdata),
    .median (median),
    .count  (count)
  );

  // result register: capture once the list is final
  always_comb begin
    out_valid_nxt = sort_ctrl.emit;
    out_beat_nxt  = out_beat_r;
    if (sort_ctrl.emit) begin
      out_beat_nxt.median_mm   = median;
      out_beat_nxt.valid_count = count;
      out_beat_nxt.usable      = (median != '0) && (median < depth_limit_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_beat_r <= out_beat_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

endmodule

FILE: sv/dm3_ram.sv
module dm3_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/dm3_sorter.sv
module dm3_sorter
  import dm3_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  sort_ctrl_t         ctrl,
  input  logic [DEPTH_W-1:0] rd_val,
  output logic [DEPTH_W-1:0] median,
  output logic [COUNT_W-1:0] count
);

  logic [DEPTH_W-1:0] s_r   [WIN_TAPS];
  logic [DEPTH_W-1:0] s_nxt [WIN_TAPS];
  logic [COUNT_W-1:0] n_r, n_nxt;
  logic [WIN_TAPS-1:0] keep;
  logic                take;

  // nonzero samples only
  assign take = ctrl.ins && (rd_val != '0);

  // sorted insertion: each slot keeps, takes the new value, or shifts up
  always_comb begin
    for (int i = 0; i < WIN_TAPS; i++) begin
      keep[i] = (COUNT_W'(i) < n_r) && (s_r[i] <= rd_val);
    end
    for (int i = 0; i < WIN_TAPS; i++) begin
      if (!take || keep[i]) begin
        s_nxt[i] = s_r[i];
      end else if (i == 0) begin
        s_nxt[i] = rd_val;
      end else if (keep[i-1]) begin
        s_nxt[i] = rd_val;
      end else begin
        s_nxt[i] = s_r[i-1];
      end
    end
    if (ctrl.clr) begin
      n_nxt = '0;
    end else if (take) begin
      n_nxt = n_r + COUNT_W'(1);
    end else begin
      n_nxt = n_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r <= '0;
    end else begin
      n_r <= n_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < WIN_TAPS; i++) begin
      s_r[i] <= s_nxt[i];
    end
  end

  assign count  = n_r;
  assign median = (n_r == '0) ? '0 : s_r[{1'b0, n_r[COUNT_W-1:1]}];

endmodule

FILE: sv/dm3_seq.sv
module dm3_seq
  import dm3_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int RW = $clog2(MAX_HEIGHT),
  localparam int AW = CW + RW
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  in_beat_t           in_beat,
  input  logic [SIZE_W-1:0]  frame_width,
  input  logic [SIZE_W-1:0]  frame_height,
  output logic               busy,
  output logic               ram_en,
  output logic               ram_we,
  output logic [AW-1:0]      ram_addr,
  output logic [DEPTH_W-1:0] ram_wdata,
  output sort_ctrl_t         sort_ctrl
);

  localparam logic [AW-1:0] LAST_ADDR = AW'((MAX_HEIGHT << CW) - 1);

  seq_state_t state_r, state_nxt;
  logic [AW-1:0]     clr_addr_r, clr_addr_nxt;
  logic [1:0]        csel_r, csel_nxt, rsel_r, rsel_nxt;
  logic              rd_pend_r, rd_pend_nxt;
  logic [SIZE_W-1:0] c_r [3];
  logic [SIZE_W-1:0] r_r [3];
  logic [SIZE_W-1:0] c_q [3];
  logic [SIZE_W-1:0] r_q [3];
  logic [SIZE_W-1:0] w_use, h_use, c_cen, r_cen, c_pick, r_pick;
  logic              accept, in_store;

  function automatic logic [SIZE_W-1:0] size_use(logic [SIZE_W-1:0] sz, int cap);
    logic [SIZE_W-1:0] res;
    if (sz == '0) begin
      res = SIZE_W'(1);
    end else if (int'(sz) > cap) begin
      res = SIZE_W'(cap);
    end else begin
      res = sz;
    end
    return res;
  endfunction

  function automatic logic [SIZE_W-1:0] clamp_ctr(logic [SIZE_W-1:0] v, logic [SIZE_W-1:0] n);
    return (v > n - SIZE_W'(1)) ? n - SIZE_W'(1) : v;
  endfunction

  function automatic logic [SIZE_W-1:0] pick3(logic [SIZE_W-1:0] a, logic [SIZE_W-1:0] b,
                                              logic [SIZE_W-1:0] c, logic [1:0] sel);
    logic [SIZE_W-1:0] res;
    unique case (sel)
      2'd0:    res = a;
      2'd1:    res = b;
      default: res = c;
    endcase
    return res;
  endfunction

  // window coordinates, edge pixels repeated
  always_comb begin
    w_use  = size_use(frame_width, MAX_WIDTH);
    h_use  = size_use(frame_height, MAX_HEIGHT);
    c_cen  = clamp_ctr({1'b0, in_beat.col}, w_use);
    r_cen  = clamp_ctr({1'b0, in_beat.row}, h_use);
    c_q[0] = (c_cen == '0) ? '0 : c_cen - SIZE_W'(1);
    c_q[1] = c_cen;
    c_q[2] = (c_cen + SIZE_W'(1) >= w_use) ? w_use - SIZE_W'(1) : c_cen + SIZE_W'(1);
    r_q[0] = (r_cen == '0) ? '0 : r_cen - SIZE_W'(1);
    r_q[1] = r_cen;
    r_q[2] = (r_cen + SIZE_W'(1) >= h_use) ? h_use - SIZE_W'(1) : r_cen + SIZE_W'(1);
  end

  assign accept   = start && !busy;
  assign in_store = (int'(in_beat.col) < MAX_WIDTH) && (int'(in_beat.row) < MAX_HEIGHT);
  assign c_pick   = pick3(c_r[0], c_r[1], c_r[2], csel_r);
  assign r_pick   = pick3(r_r[0], r_r[1], r_r[2], rsel_r);

  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    csel_nxt       = csel_r;
    rsel_nxt       = rsel_r;
    rd_pend_nxt    = 1'b0;
    busy           = 1'b1;
    ram_en         = 1'b0;
    ram_we         = 1'b0;
    ram_addr       = {RW'(r_pick), CW'(c_pick)};
    ram_wdata      = '0;
    sort_ctrl      = '0;
    sort_ctrl.ins  = rd_pend_r;

    unique case (state_r)
      ST_CLEAR: begin
        ram_en   = 1'b1;
        ram_we   = 1'b1;
        ram_addr = clr_addr_r;
        if (clr_addr_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + AW'(1);
        end
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (accept) begin
          if (in_beat.op == OP_QUERY) begin
            state_nxt     = ST_READ;
            csel_nxt      = '0;
            rsel_nxt      = '0;
            sort_ctrl.clr = 1'b1;
          end else if (in_store) begin
            ram_en    = 1'b1;
            ram_we    = 1'b1;
            ram_addr  = {RW'(in_beat.row), CW'(in_beat.col)};
            ram_wdata = in_beat.sample_ok ? in_beat.depth_mm : '0;
          end
        end
      end
      ST_READ: begin
        ram_en      = 1'b1;
        rd_pend_nxt = 1'b1;
        if (rsel_r == 2'd2) begin
          rsel_nxt = '0;
          if (csel_r == 2'd2) begin
            state_nxt = ST_SETTLE;
          end else begin
            csel_nxt = csel_r + 2'd1;
          end
        end else begin
          rsel_nxt = rsel_r + 2'd1;
        end
      end
      ST_SETTLE: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        sort_ctrl.emit = 1'b1;
        state_nxt      = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
      csel_r     <= '0;
      rsel_r     <= '0;
      rd_pend_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      csel_r     <= csel_nxt;
      rsel_r     <= rsel_nxt;
      rd_pend_r  <= rd_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_beat.op == OP_QUERY) begin
      for (int i = 0; i < 3; i++) begin
        c_r[i] <= c_q[i];
        r_r[i] <= r_q[i];
      end
    end
  end

endmodule
